>>> rtl/tks_pkg.sv
// ----------------------------------------------------------------------------
// tks_pkg
// Shared constants, control word layout and microcode for top_k_select_ids.
// ----------------------------------------------------------------------------
package tks_pkg;

    localparam int MAX_ITEMS_DEF = 64;
    localparam int SCORE_W       = 32;
    localparam int ID_W          = 6;
    localparam int KEEP_W        = 7;
    localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd1;

    // microcode step addresses
    localparam int UPC_W = 4;
    localparam logic [UPC_W-1:0] ST_IDLE  = 4'd0;
    localparam logic [UPC_W-1:0] ST_K0    = 4'd1;
    localparam logic [UPC_W-1:0] ST_K1    = 4'd2;
    localparam logic [UPC_W-1:0] ST_K2    = 4'd3;
    localparam logic [UPC_W-1:0] ST_C0    = 4'd4;
    localparam logic [UPC_W-1:0] ST_C1    = 4'd5;
    localparam logic [UPC_W-1:0] ST_C2    = 4'd6;
    localparam logic [UPC_W-1:0] ST_SWAP  = 4'd7;
    localparam logic [UPC_W-1:0] ST_EMIT  = 4'd8;
    localparam logic [UPC_W-1:0] ST_NEXTK = 4'd9;

    // jump conditions
    localparam int COND_W = 3;
    localparam logic [COND_W-1:0] CD_ALWAYS   = 3'd0;
    localparam logic [COND_W-1:0] CD_START    = 3'd1;
    localparam logic [COND_W-1:0] CD_J_END    = 3'd2;
    localparam logic [COND_W-1:0] CD_OUT_FREE = 3'd3;
    localparam logic [COND_W-1:0] CD_K_END    = 3'd4;

    typedef struct packed {
        logic              in_rdy;     // take input items
        logic              rd_sel_j;   // perm read at j, else at k
        logic              ld_kinit;   // best <= k, j <= k+1
        logic              ld_kid;     // capture perm[k]
        logic              ld_bscore;  // capture score of perm[k]
        logic              ld_cand;    // cand_pos <= j, j++
        logic              ld_cand_id; // capture perm[j]
        logic              cmp_upd;    // compare candidate, keep the larger
        logic              wr_k;       // perm[k] <= best_id
        logic              wr_best;    // perm[best] <= k_id
        logic              emit;       // load result register when free
        logic              fin;        // close set once k reaches the keep count
        logic [COND_W-1:0] cond;
        logic [UPC_W-1:0]  t_addr;
        logic [UPC_W-1:0]  f_addr;
    } ctrl_word_t;

    typedef struct packed {
        logic start;
        logic j_end;
        logic out_free;
        logic k_end;
    } seq_flags_t;

    function automatic ctrl_word_t ucode_word(input logic [UPC_W-1:0] addr);
        ctrl_word_t w;
        w = '0;
        case (addr)
            ST_IDLE:
            begin
                w.in_rdy = 1'b1;
                w.cond   = CD_START;
                w.t_addr = ST_K0;
                w.f_addr = ST_IDLE;
            end
            ST_K0:
            begin
                w.ld_kinit = 1'b1;
                w.t_addr   = ST_K1;
            end
            ST_K1:
            begin
                w.ld_kid = 1'b1;
                w.t_addr = ST_K2;
            end
            ST_K2:
            begin
                w.ld_bscore = 1'b1;
                w.cond      = CD_J_END;
                w.t_addr    = ST_SWAP;
                w.f_addr    = ST_C0;
            end
            ST_C0:
            begin
                w.rd_sel_j = 1'b1;
                w.ld_cand  = 1'b1;
                w.t_addr   = ST_C1;
            end
            ST_C1:
            begin
                w.ld_cand_id = 1'b1;
                w.t_addr     = ST_C2;
            end
            ST_C2:
            begin
                w.cmp_upd = 1'b1;
                w.cond    = CD_J_END;
                w.t_addr  = ST_SWAP;
                w.f_addr  = ST_C0;
            end
            ST_SWAP:
            begin
                w.wr_k   = 1'b1;
                w.t_addr = ST_EMIT;
            end
            ST_EMIT:
            begin
                w.wr_best = 1'b1;
                w.emit    = 1'b1;
                w.cond    = CD_OUT_FREE;
                w.t_addr  = ST_NEXTK;
                w.f_addr  = ST_EMIT;
            end
            ST_NEXTK:
            begin
                w.fin    = 1'b1;
                w.cond   = CD_K_END;
                w.t_addr = ST_IDLE;
                w.f_addr = ST_K0;
            end
            default:
            begin
                w.t_addr = ST_IDLE;
                w.f_addr = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

>>> rtl/top_k_select_ids.sv
// ----------------------------------------------------------------------------
// top_k_select_ids
// Collects a set of signed scores and returns the ids of the top keep_count.
// ----------------------------------------------------------------------------
// Scores arrive one per input transfer and are stored in arrival order;
// last_score = 1 closes the set. A microcoded sequencer then runs a
// partial selection sort over an id permutation held in a RAM, using a
// strict signed greater-than, so among equal scores the earliest current
// position wins. min(keep_count, count) ids come out in descending score
// order, the final one with last_of_run set; truncated is set on every result
// of a set that lost scores beyond MAX_ITEMS. A set with nothing to emit
// closes at once. While a set is being sorted no input is taken. Each
// compare needs a permutation RAM read, a score RAM read and the compare
// itself; output back-pressure stalls the sequencer at the result register.
// The final result may still wait in the output register while the next set
// loads. keep_count is written over its own channel, which is always ready.
module top_k_select_ids #(
    parameter int MAX_ITEMS = tks_pkg::MAX_ITEMS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tks_pkg::KEEP_W-1:0]        keep_count,
    // score input
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [tks_pkg::SCORE_W-1:0] score_value,
    input  logic                              last_score,
    // results
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [tks_pkg::ID_W-1:0]          kept_id,
    output logic                              last_of_run,
    output logic                              truncated
);

    localparam int AW = $clog2(MAX_ITEMS);      // RAM address / id bits
    localparam int CW = $clog2(MAX_ITEMS + 1);  // count bits

    // control
    tks_pkg::ctrl_word_t ctrl;
    tks_pkg::seq_flags_t flags;

    // configuration register
    logic [tks_pkg::KEEP_W-1:0] keep_count_reg;

    // set bookkeeping
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          ovf_reg;
    logic          ovf_next;
    logic [CW-1:0] n_reg;
    logic [CW-1:0] keep_reg;

    // sort datapath
    logic [CW-1:0] k_reg;
    logic [CW-1:0] j_reg;
    logic [AW-1:0] best_reg;
    logic [AW-1:0] best_id_reg;
    logic [AW-1:0] k_id_reg;
    logic [AW-1:0] cand_pos_reg;
    logic [AW-1:0] cand_id_reg;
    logic signed [tks_pkg::SCORE_W-1:0] best_score_reg;

    // RAMs
    logic signed [tks_pkg::SCORE_W-1:0] score_mem [MAX_ITEMS];
    logic [AW-1:0]                      perm_mem  [MAX_ITEMS];
    logic signed [tks_pkg::SCORE_W-1:0] score_q;
    logic [AW-1:0]                      perm_q;
    logic [AW-1:0]                      perm_raddr;
    logic                               perm_we;
    logic [AW-1:0]                      perm_waddr;
    logic [AW-1:0]                      perm_wdata;

    // result register
    logic                   out_valid_reg;
    logic [tks_pkg::ID_W-1:0] kept_id_reg;
    logic                   last_reg;
    logic                   trunc_reg;

    // input side
    logic          in_fire;
    logic          full;
    logic [CW-1:0] count_after;
    logic [CW-1:0] keep_eff;
    logic          out_free;
    logic          emit_fire;
    logic [CW-1:0] k_inc;

    assign cfg_ready = 1'b1;
    assign in_ready  = ctrl.in_rdy;
    assign in_fire   = in_valid && in_ready;

    assign full        = (count_reg == CW'(MAX_ITEMS));
    assign count_after = full ? count_reg : CW'(count_reg + 1'b1);
    assign keep_eff    = (tks_pkg::KEEP_W'(count_after) < keep_count_reg)
                         ? count_after : CW'(keep_count_reg);

    assign out_free  = !out_valid_reg || out_ready;
    assign emit_fire = ctrl.emit && out_free;
    assign k_inc     = CW'(k_reg + 1'b1);

    assign flags.start    = in_fire && last_score && (keep_eff != '0);
    assign flags.j_end    = (j_reg >= n_reg);
    assign flags.out_free = out_free;
    assign flags.k_end    = (k_reg == keep_reg);

    tks_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_count_reg <= tks_pkg::KEEP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            keep_count_reg <= keep_count;
        end
    end

    // count and overflow: advance on load, clear when a set closes
    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (in_fire)
        begin
            count_next = count_after;
            ovf_next   = ovf_reg || full;
            if (last_score && (keep_eff == '0))
            begin
                count_next = '0;
                ovf_next   = 1'b0;
            end
        end
        else if (ctrl.fin && flags.k_end)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    // permutation write port: identity on load, swap halves during sort
    always_comb
    begin
        perm_we    = 1'b0;
        perm_waddr = count_reg[AW-1:0];
        perm_wdata = count_reg[AW-1:0];
        if (in_fire && !full)
        begin
            perm_we = 1'b1;
        end
        else if (ctrl.wr_k)
        begin
            perm_we    = 1'b1;
            perm_waddr = k_reg[AW-1:0];
            perm_wdata = best_id_reg;
        end
        else if (ctrl.wr_best)
        begin
            perm_we    = 1'b1;
            perm_waddr = best_reg;
            perm_wdata = k_id_reg;
        end
    end

    assign perm_raddr = ctrl.rd_sel_j ? j_reg[AW-1:0] : k_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (perm_we)
        begin
            perm_mem[perm_waddr] <= perm_wdata;
        end
        perm_q <= perm_mem[perm_raddr];
    end

    // score RAM: read address follows the permutation read data
    always_ff @(posedge clk)
    begin
        if (in_fire && !full)
        begin
            score_mem[count_reg[AW-1:0]] <= score_value;
        end
        score_q <= score_mem[perm_q];
    end

    // set parameters latched when a set closes with ids to emit
    always_ff @(posedge clk)
    begin
        if (flags.start)
        begin
            n_reg    <= count_after;
            keep_reg <= keep_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= '0;
        end
        else if (flags.start)
        begin
            k_reg <= '0;
        end
        else if (emit_fire)
        begin
            k_reg <= k_inc;
        end
    end

    // sort datapath registers
    always_ff @(posedge clk)
    begin
        if (ctrl.ld_kinit)
        begin
            best_reg <= k_reg[AW-1:0];
            j_reg    <= k_inc;
        end
        if (ctrl.ld_kid)
        begin
            best_id_reg <= perm_q;
            k_id_reg    <= perm_q;
        end
        if (ctrl.ld_bscore)
        begin
            best_score_reg <= score_q;
        end
        if (ctrl.ld_cand)
        begin
            cand_pos_reg <= j_reg[AW-1:0];
            j_reg        <= CW'(j_reg + 1'b1);
        end
        if (ctrl.ld_cand_id)
        begin
            cand_id_reg <= perm_q;
        end
        if (ctrl.cmp_upd && (score_q > best_score_reg))
        begin
            best_reg       <= cand_pos_reg;
            best_id_reg    <= cand_id_reg;
            best_score_reg <= score_q;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            kept_id_reg <= tks_pkg::ID_W'(best_id_reg);
            last_reg    <= (k_inc == keep_reg);
            trunc_reg   <= ovf_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kept_id     = kept_id_reg;
    assign last_of_run = last_reg;
    assign truncated   = trunc_reg;

    // the fill count never passes capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ITEMS))
        else $error("item count above capacity");

    // during a sort the effective keep is nonzero and within the set
    a_keep_range: assert property (@(posedge clk) disable iff (!rst_n)
        !ctrl.in_rdy |-> (keep_reg != '0) && (keep_reg <= n_reg))
        else $error("keep out of range during sort");

    // a chosen position lies between k and the end of the set
    a_best_range: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |-> (CW'(best_reg) >= k_reg) && (CW'(best_reg) < n_reg))
        else $error("selected position out of range");

    // last_of_run is flagged exactly when the sort returns to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |=> (last_of_run == flags.k_end))
        else $error("last flag disagrees with sequencer");

endmodule

>>> rtl/tks_useq.sv
// ----------------------------------------------------------------------------
// tks_useq
// Step counter and control store for the selection sequencer.
// ----------------------------------------------------------------------------
module tks_useq (
    input  logic                clk,
    input  logic                rst_n,
    input  tks_pkg::seq_flags_t flags,
    output tks_pkg::ctrl_word_t ctrl
);

    logic [tks_pkg::UPC_W-1:0] upc_reg;
    logic [tks_pkg::UPC_W-1:0] upc_next;
    logic                      cond_true;

    assign ctrl = tks_pkg::ucode_word(upc_reg);

    always_comb
    begin
        case (ctrl.cond)
            tks_pkg::CD_ALWAYS:   cond_true = 1'b1;
            tks_pkg::CD_START:    cond_true = flags.start;
            tks_pkg::CD_J_END:    cond_true = flags.j_end;
            tks_pkg::CD_OUT_FREE: cond_true = flags.out_free;
            tks_pkg::CD_K_END:    cond_true = flags.k_end;
            default:              cond_true = 1'b1;
        endcase
        upc_next = cond_true ? ctrl.t_addr : ctrl.f_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= tks_pkg::ST_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule
